[rtl/tffa_pkg.sv]
// package for the timed first-fit allocator
// slot table sizes, field widths, the sequencer state type and shared structs
// no dependencies
package tffa_pkg;

    localparam int SLOTS        = 64;
    localparam int LENGTH_BITS  = 10;
    localparam int IDX_W        = $clog2(SLOTS);
    localparam int CNT_W        = $clog2(SLOTS + 1);
    localparam int TIME_W       = 32;
    localparam int REQ_LEN_W    = 10;
    localparam int OWNER_W      = 10;
    localparam int SLOT_INDEX_W = 6;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_RD   = 5'b00010,
        ST_CHK  = 5'b00100,
        ST_DEC  = 5'b01000,
        ST_FIN  = 5'b10000
    } state_t;

    typedef struct packed {
        logic                   wr_en;
        logic                   wr_cap;
        logic [IDX_W-1:0]       addr;
        logic [TIME_W-1:0]      start;
        logic [LENGTH_BITS-1:0] cap;
        logic [OWNER_W-1:0]     owner;
    } slot_wr_t;

    typedef struct packed {
        logic expired;
        logic fits;
    } cmp_res_t;

endpackage

[rtl/tffa_slot_ram.sv]
// slot table storage: start time, capacity and owner per slot
// one write port, one registered read port; uses tffa_pkg
module tffa_slot_ram
    import tffa_pkg::*;
(
    input  logic                   aclk,
    input  slot_wr_t               wr,
    input  logic [IDX_W-1:0]       rd_addr,
    output logic [TIME_W-1:0]      rd_start,
    output logic [LENGTH_BITS-1:0] rd_cap
);

    logic [TIME_W-1:0]      start_mem [SLOTS];
    logic [LENGTH_BITS-1:0] cap_mem   [SLOTS];
    logic [OWNER_W-1:0]     owner_mem [SLOTS];

    always_ff @(posedge aclk) begin
        if (wr.wr_en) begin
            start_mem[wr.addr] <= wr.start;
            owner_mem[wr.addr] <= wr.owner;
            if (wr.wr_cap) begin
                cap_mem[wr.addr] <= wr.cap;
            end
        end
        rd_start <= start_mem[rd_addr];
        rd_cap   <= cap_mem[rd_addr];
    end

endmodule

[rtl/tffa_cmp_unit.sv]
// shared compare unit: lease expiry test and capacity fit test for one slot
// uses tffa_pkg
module tffa_cmp_unit
    import tffa_pkg::*;
(
    input  logic [TIME_W-1:0]      start,
    input  logic [TIME_W-1:0]      lease,
    input  logic [TIME_W-1:0]      now,
    input  logic [LENGTH_BITS-1:0] cap,
    input  logic [LENGTH_BITS-1:0] len,
    output cmp_res_t               res
);

    logic [TIME_W:0] expiry;

    assign expiry      = {1'b0, start} + {1'b0, lease};
    assign res.expired = {1'b0, now} >= expiry;
    assign res.fits    = cap >= len;

endmodule

[rtl/timed_first_fit_allocator_core.sv]
// timed first-fit allocator: lease expiry sweep then first-fit slot pick
// each request walks the used slots, a read state then a check state per slot,
// then a decide state and a finish state; the result is registered at the output
// requests are taken only in the idle state, not before the last result is out
// reset clears lease time, busy bits, fill count and handshakes; the table is not cleared
// uses tffa_pkg, tffa_slot_ram, tffa_cmp_unit
module timed_first_fit_allocator_core
    import tffa_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_wr_en,
    input  logic [TIME_W-1:0]       cfg_wr_data,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [REQ_LEN_W-1:0]    s_req_length,
    input  logic [TIME_W-1:0]       s_req_time,
    input  logic [OWNER_W-1:0]      s_owner_tag,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [SLOT_INDEX_W-1:0] m_slot_index,
    output logic                    m_reused,
    output logic                    m_table_full
);

    state_t                 state_reg, state_next;
    logic [TIME_W-1:0]      lease_reg;
    logic [SLOTS-1:0]       busy_reg, busy_next;
    logic [CNT_W-1:0]       used_reg, used_next;
    logic [CNT_W-1:0]       scan_reg, scan_next;
    logic                   hit_reg, hit_next;
    logic [IDX_W-1:0]       hit_idx_reg, hit_idx_next;
    logic [LENGTH_BITS-1:0] len_reg;
    logic [TIME_W-1:0]      now_reg;
    logic [OWNER_W-1:0]     tag_reg;
    logic [IDX_W-1:0]       res_idx_reg, res_idx_next;
    logic                   res_reused_reg, res_reused_next;
    logic                   res_full_reg, res_full_next;
    logic                   m_valid_reg;
    logic [SLOT_INDEX_W-1:0] m_idx_reg;
    logic                   m_reused_reg, m_full_reg;

    logic [IDX_W-1:0]       scan_idx;
    logic [TIME_W-1:0]      rd_start;
    logic [LENGTH_BITS-1:0] rd_cap;
    slot_wr_t               wr;
    cmp_res_t               cmp;
    logic                   in_acc;
    logic                   out_free;
    logic                   busy_after;

    assign scan_idx = scan_reg[IDX_W-1:0];
    assign in_acc   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);

    tffa_slot_ram u_ram (
        .aclk     (aclk),
        .wr       (wr),
        .rd_addr  (scan_idx),
        .rd_start (rd_start),
        .rd_cap   (rd_cap)
    );

    tffa_cmp_unit u_cmp (
        .start (rd_start),
        .lease (lease_reg),
        .now   (now_reg),
        .cap   (rd_cap),
        .len   (len_reg),
        .res   (cmp)
    );

    assign busy_after = busy_reg[scan_idx] && !cmp.expired;

    always_comb begin
        state_next      = state_reg;
        busy_next       = busy_reg;
        used_next       = used_reg;
        scan_next       = scan_reg;
        hit_next        = hit_reg;
        hit_idx_next    = hit_idx_reg;
        res_idx_next    = res_idx_reg;
        res_reused_next = res_reused_reg;
        res_full_next   = res_full_reg;
        wr.wr_en        = 1'b0;
        wr.wr_cap       = 1'b0;
        wr.addr         = hit_idx_reg;
        wr.start        = now_reg;
        wr.cap          = len_reg;
        wr.owner        = tag_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    scan_next  = '0;
                    hit_next   = 1'b0;
                    state_next = (used_reg == '0) ? ST_DEC : ST_RD;
                end
            end
            ST_RD: begin
                state_next = ST_CHK;
            end
            ST_CHK: begin
                busy_next[scan_idx] = busy_after;
                if (!busy_after && cmp.fits && !hit_reg) begin
                    hit_next     = 1'b1;
                    hit_idx_next = scan_idx;
                end
                scan_next  = scan_reg + CNT_W'(1);
                state_next = (scan_reg + CNT_W'(1) == used_reg) ? ST_DEC : ST_RD;
            end
            ST_DEC: begin
                state_next = ST_FIN;
                if (hit_reg) begin
                    wr.wr_en               = 1'b1;
                    busy_next[hit_idx_reg] = 1'b1;
                    res_idx_next           = hit_idx_reg;
                    res_reused_next        = 1'b1;
                    res_full_next          = 1'b0;
                end else if (used_reg == CNT_W'(SLOTS)) begin
                    res_idx_next    = '0;
                    res_reused_next = 1'b0;
                    res_full_next   = 1'b1;
                end else begin
                    wr.wr_en                       = 1'b1;
                    wr.wr_cap                      = 1'b1;
                    wr.addr                        = used_reg[IDX_W-1:0];
                    busy_next[used_reg[IDX_W-1:0]] = 1'b1;
                    used_next                      = used_reg + CNT_W'(1);
                    res_idx_next                   = used_reg[IDX_W-1:0];
                    res_reused_next                = 1'b0;
                    res_full_next                  = 1'b0;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            lease_reg   <= '0;
            busy_reg    <= '0;
            used_reg    <= '0;
            scan_reg    <= '0;
            hit_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
            used_reg  <= used_next;
            scan_reg  <= scan_next;
            hit_reg   <= hit_next;
            if (cfg_wr_en) begin
                lease_reg <= cfg_wr_data;
            end
            if (state_reg == ST_FIN && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        hit_idx_reg    <= hit_idx_next;
        res_idx_reg    <= res_idx_next;
        res_reused_reg <= res_reused_next;
        res_full_reg   <= res_full_next;
        if (in_acc) begin
            len_reg <= LENGTH_BITS'(s_req_length);
            now_reg <= s_req_time;
            tag_reg <= s_owner_tag;
        end
        if (state_reg == ST_FIN && out_free) begin
            m_idx_reg    <= SLOT_INDEX_W'(res_idx_reg);
            m_reused_reg <= res_reused_reg;
            m_full_reg   <= res_full_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_slot_index = m_idx_reg;
    assign m_reused     = m_reused_reg;
    assign m_table_full = m_full_reg;

endmodule

[tb/sv/timed_first_fit_allocator_checker.sv]
// grant checker for the timed first-fit allocator: watches the lease, request and grant ports
// keeps its own slot table to predict every grant and compares grants in order
// uses tffa_pkg
module timed_first_fit_allocator_checker
    import tffa_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_wr_en,
    input  logic [TIME_W-1:0]       cfg_wr_data,
    input  logic                    s_valid,
    input  logic                    s_ready,
    input  logic [REQ_LEN_W-1:0]    s_req_length,
    input  logic [TIME_W-1:0]       s_req_time,
    input  logic [OWNER_W-1:0]      s_owner_tag,
    input  logic                    m_valid,
    input  logic                    m_ready,
    input  logic [SLOT_INDEX_W-1:0] m_slot_index,
    input  logic                    m_reused,
    input  logic                    m_table_full,
    output int                      fail_count,
    output int                      outstanding
);

    typedef struct packed {
        logic [SLOT_INDEX_W-1:0] slot_index;
        logic                    reused;
        logic                    table_full;
    } grant_t;

    logic [TIME_W-1:0]      lease_ticks;
    logic [LENGTH_BITS-1:0] slot_cap_m   [SLOTS];
    logic [TIME_W-1:0]      slot_start_m [SLOTS];
    logic                   slot_busy_m  [SLOTS];
    int                     slots_filled;
    grant_t                 grants_due[$];

    initial begin
        fail_count  = 0;
        outstanding = 0;
    end

    function automatic grant_t predict_grant(input logic [REQ_LEN_W-1:0] length,
                                             input logic [TIME_W-1:0]    now);
        grant_t                 g;
        logic [LENGTH_BITS-1:0] need;
        g    = '0;
        need = length[LENGTH_BITS-1:0];
        // expiry sweep, sum kept at 33 bits so it never wraps
        for (int i = 0; i < slots_filled; i++) begin
            if ({1'b0, now} >= {1'b0, slot_start_m[i]} + {1'b0, lease_ticks})
                slot_busy_m[i] = 1'b0;
        end
        for (int i = 0; i < slots_filled; i++) begin
            if (!slot_busy_m[i] && slot_cap_m[i] >= need) begin
                slot_busy_m[i]  = 1'b1;
                slot_start_m[i] = now;
                g.slot_index    = SLOT_INDEX_W'(i);
                g.reused        = 1'b1;
                return g;
            end
        end
        if (slots_filled >= SLOTS) begin
            g.table_full = 1'b1;
            return g;
        end
        slot_cap_m[slots_filled]   = need;
        slot_start_m[slots_filled] = now;
        slot_busy_m[slots_filled]  = 1'b1;
        g.slot_index               = SLOT_INDEX_W'(slots_filled);
        slots_filled++;
        return g;
    endfunction

    task automatic flag_grant(input string why, input grant_t want, input grant_t got);
        fail_count++;
        if (fail_count <= 10)
            $display("%0t grant mismatch (%s): expected idx %0d reused %0b full %0b,",
                     $realtime, why, want.slot_index, want.reused, want.table_full,
                     " got idx %0d reused %0b full %0b",
                     got.slot_index, got.reused, got.table_full);
    endtask

    always @(posedge aclk) begin
        grant_t got;
        grant_t want;
        if (!aresetn) begin
            lease_ticks  = '0;
            slots_filled = 0;
            for (int i = 0; i < SLOTS; i++)
                slot_busy_m[i] = 1'b0;
            grants_due.delete();
        end else begin
            if (m_valid && m_ready) begin
                got = '{m_slot_index, m_reused, m_table_full};
                if (grants_due.size() == 0) begin
                    flag_grant("no grant due", '0, got);
                end else begin
                    want = grants_due.pop_front();
                    if (got.slot_index !== want.slot_index || got.reused !== want.reused
                        || got.table_full !== want.table_full)
                        flag_grant("field", want, got);
                end
            end
            if (cfg_wr_en)
                lease_ticks = cfg_wr_data;
            if (s_valid && s_ready)
                grants_due.push_back(predict_grant(s_req_length, s_req_time));
        end
        outstanding = grants_due.size();
    end

endmodule

[tb/sv/timed_first_fit_allocator_core_tb.sv]
// testbench top for the timed first-fit allocator: clock, reset, lease writes and request items
// runs directed then random phases under varied idling and hands the verdict from the checker
// uses tffa_pkg, timed_first_fit_allocator_core, timed_first_fit_allocator_checker
module timed_first_fit_allocator_core_tb;
    import tffa_pkg::*;

    logic                    aclk;
    logic                    aresetn;
    logic                    cfg_wr_en;
    logic [TIME_W-1:0]       cfg_wr_data;
    logic                    s_valid;
    logic                    s_ready;
    logic [REQ_LEN_W-1:0]    s_req_length;
    logic [TIME_W-1:0]       s_req_time;
    logic [OWNER_W-1:0]      s_owner_tag;
    logic                    m_valid;
    logic                    m_ready;
    logic [SLOT_INDEX_W-1:0] m_slot_index;
    logic                    m_reused;
    logic                    m_table_full;
    int                      fail_count;
    int                      outstanding;

    logic [TIME_W-1:0] now_ticks;
    int unsigned       sender_idle_pct;
    int unsigned       recv_stall_pct;
    int                hold_requests;
    int                hold_seen;
    int                hold_left;

    timed_first_fit_allocator_core DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_req_length (s_req_length),
        .s_req_time   (s_req_time),
        .s_owner_tag  (s_owner_tag),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_slot_index (m_slot_index),
        .m_reused     (m_reused),
        .m_table_full (m_table_full)
    );

    timed_first_fit_allocator_checker grant_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_req_length (s_req_length),
        .s_req_time   (s_req_time),
        .s_owner_tag  (s_owner_tag),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_slot_index (m_slot_index),
        .m_reused     (m_reused),
        .m_table_full (m_table_full),
        .fail_count   (fail_count),
        .outstanding  (outstanding)
    );

    always begin
        aclk = 1'b0;
        #2;
        aclk = 1'b1;
        #2;
    end

    initial begin
        m_ready       = 1'b0;
        hold_requests = 0;
        hold_seen     = 0;
        hold_left     = 0;
    end

    // grant side: random stalls plus a long hold-off when asked
    always @(negedge aclk) begin
        if (hold_seen != hold_requests) begin
            hold_seen = hold_requests;
            hold_left = 400;
        end
        if (hold_left > 0) begin
            m_ready = 1'b0;
            hold_left--;
        end else begin
            m_ready = ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial begin
        #4000000;
        $display("status: fail");
        $finish;
    end

    task automatic offer_request(input logic [REQ_LEN_W-1:0] length,
                                 input logic [TIME_W-1:0]    stamp,
                                 input logic [OWNER_W-1:0]   owner);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid      = 1'b1;
        s_req_length = length;
        s_req_time   = stamp;
        s_owner_tag  = owner;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic wait_all_granted();
        s_valid = 1'b0;
        while (outstanding != 0)
            @(negedge aclk);
    endtask

    task automatic write_lease(input logic [TIME_W-1:0] ticks);
        wait_all_granted();
        cfg_wr_en   = 1'b1;
        cfg_wr_data = ticks;
        @(negedge aclk);
        cfg_wr_en   = 1'b0;
    endtask

    task automatic random_request(input int unsigned step_max);
        logic [REQ_LEN_W-1:0] length;
        case ($urandom_range(9))
            0: length = '0;
            1: length = '1;
            2, 3, 4, 5: length = REQ_LEN_W'($urandom_range(1023));
            default: length = REQ_LEN_W'($urandom_range(127));
        endcase
        // occasional jump anywhere, forwards or backwards
        if ($urandom_range(15) == 0)
            now_ticks = $urandom;
        else
            now_ticks = now_ticks + $urandom_range(step_max);
        offer_request(length, now_ticks, OWNER_W'($urandom_range(1023)));
    endtask

    initial begin
        logic [TIME_W-1:0] lease_plan [6];
        int unsigned       step_plan [6];
        aresetn         = 1'b0;
        cfg_wr_en       = 1'b0;
        cfg_wr_data     = '0;
        s_valid         = 1'b0;
        s_req_length    = '0;
        s_req_time      = '0;
        s_owner_tag     = '0;
        now_ticks       = '0;
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        lease_plan = '{32'd40, 32'h0100_0000, 32'd300, 32'd0, 32'd0, 32'hFFFF_FFFF};
        step_plan  = '{20, 20, 40, 2000, 50, 1000};
        lease_plan[3] = $urandom;
        repeat (6) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // zero lease: a slot in use expires on any item whose time is not before its start
        write_lease('0);
        offer_request('0, '0, '0);
        offer_request('1, '1, '1);
        offer_request('0, 32'd5, 10'h155);
        offer_request(10'd512, 32'd5, 10'h2AA);
        // widest lease: expiry only at the very top of the time range
        write_lease('1);
        offer_request(10'd1, '0, 10'h3F0);
        offer_request(10'd1, '1, 10'h00F);
        offer_request(10'd1, '1, 10'h001);
        write_lease(32'd10);
        offer_request(10'd2, 32'd20, 10'h0F0);
        offer_request('1, 32'd20, 10'h30C);
        offer_request('0, 32'd21, 10'h0C3);

        for (int p = 0; p < 6; p++) begin
            write_lease(lease_plan[p]);
            case (p % 4)
                0: begin
                    sender_idle_pct = 0;
                    recv_stall_pct  = 0;
                end
                1: begin
                    sender_idle_pct = 88;
                    recv_stall_pct  = 0;
                end
                2: begin
                    sender_idle_pct = 0;
                    recv_stall_pct  = 88;
                end
                default: begin
                    sender_idle_pct = 24;
                    recv_stall_pct  = 24;
                end
            endcase
            if (p == 2)
                hold_requests++;
            for (int k = 0; k < 155; k++) begin
                if (p == 2 && k == 77)
                    wait_all_granted();
                random_request(step_plan[p]);
            end
        end

        wait_all_granted();
        repeat (200) @(negedge aclk);
        if (fail_count == 0 && outstanding == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
